// ===== hdl/sktab_pkg.sv =====
package sktab_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CAP_W       = 7;
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int WORD_W      = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_DUP  = 2'd2,
        ST_MISS = 2'd3
    } status_t;

    // one table row
    typedef struct packed {
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] pay_a;
        logic [WORD_W-1:0] pay_b;
        logic [WORD_W-1:0] pay_c;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic    load_item;
        logic    scan_init;
        logic    scan;
        logic    shift;
        logic    place;
        logic    res_load;
        logic    res_payload;
        status_t res_status;
        logic    out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_lookup;
        logic full;
        logic scan_hit;
        logic scan_stop;
        logic shift_done;
        logic out_busy;
    } dp_stat_t;

endpackage

// ===== hdl/sktab_ctrl.sv =====
module sktab_ctrl
    import sktab_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_SHIFT,
        S_PLACE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and datapath commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.full)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_FULL;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_hit)
                begin
                    cmd.res_load    = 1'b1;
                    cmd.res_payload = stat.is_lookup;
                    cmd.res_status  = stat.is_lookup ? ST_OK : ST_DUP;
                    state_next      = S_DONE;
                end
                else if (stat.scan_stop)
                begin
                    if (stat.is_lookup)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_MISS;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.shift_done)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                cmd.place      = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/sktab_dp.sv =====
module sktab_dp
    import sktab_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    input  logic              opcode,
    input  logic [WORD_W-1:0] key,
    input  logic [WORD_W-1:0] payload_a,
    input  logic [WORD_W-1:0] payload_b,
    input  logic [WORD_W-1:0] payload_c,
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [WORD_W-1:0] found_a,
    output logic [WORD_W-1:0] found_b,
    output logic [WORD_W-1:0] found_c
);

    // table memory
    entry_t mem [TABLE_DEPTH];

    // control registers
    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] ptr_reg;
    logic [CNT_W-1:0] ptr_next;
    logic             rd_pend_reg;
    logic             out_valid_reg;

    // payload registers
    opcode_t           op_reg;
    entry_t            item_reg;
    logic [CNT_W-1:0]  pos_reg;
    entry_t            rd_data_reg;
    logic [IDX_W-1:0]  rd_addr_reg;
    status_t           res_status_reg;
    logic [WORD_W-1:0] res_a_reg;
    logic [WORD_W-1:0] res_b_reg;
    logic [WORD_W-1:0] res_c_reg;
    status_t           out_status_reg;
    logic [WORD_W-1:0] out_a_reg;
    logic [WORD_W-1:0] out_b_reg;
    logic [WORD_W-1:0] out_c_reg;

    // combinational helpers
    logic [CNT_W-1:0] ptr_dec;
    logic             more_to_read;
    logic             key_eq;
    logic             key_gt;
    logic             scan_hit;
    logic             scan_gt;
    logic             scan_end;
    logic             scan_done;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             is_full;

    // scan compare against the row read last cycle
    assign ptr_dec      = ptr_reg - CNT_W'(1);
    assign more_to_read = (ptr_reg < count_reg);
    assign key_eq       = (rd_data_reg.key == item_reg.key);
    assign key_gt       = (rd_data_reg.key > item_reg.key);
    assign scan_hit     = rd_pend_reg && key_eq;
    assign scan_gt      = rd_pend_reg && !key_eq && key_gt;
    assign scan_end     = !rd_pend_reg && !more_to_read;
    assign scan_done    = scan_hit || scan_gt || scan_end;

    // full check against effective capacity
    assign is_full = (op_reg == OP_INSERT) &&
                     ((count_reg >= CNT_W'(TABLE_DEPTH)) ||
                      (CMP_W'(count_reg) >= CMP_W'(cap_reg)));

    // read port: ascending during scan, descending during shift
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = ptr_reg[IDX_W-1:0];
        if (cmd.scan)
        begin
            rd_en   = !scan_done && more_to_read;
            rd_addr = ptr_reg[IDX_W-1:0];
        end
        else if (cmd.shift)
        begin
            rd_en   = (ptr_reg > pos_reg);
            rd_addr = ptr_dec[IDX_W-1:0];
        end
    end

    // write port: row moves up one place, or the new row lands
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_addr_reg + IDX_W'(1);
        wr_data = rd_data_reg;
        if (cmd.place)
        begin
            wr_en   = 1'b1;
            wr_addr = pos_reg[IDX_W-1:0];
            wr_data = item_reg;
        end
        else if (cmd.shift && rd_pend_reg)
        begin
            wr_en = 1'b1;
        end
    end

    // pointer update
    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.scan_init)
        begin
            ptr_next = '0;
        end
        else if (cmd.scan)
        begin
            if (scan_done)
            begin
                ptr_next = count_reg;
            end
            else if (rd_en)
            begin
                ptr_next = ptr_reg + CNT_W'(1);
            end
        end
        else if (cmd.shift && rd_en)
        begin
            ptr_next = ptr_dec;
        end
    end

    // memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            ptr_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.place)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            ptr_reg     <= ptr_next;
            rd_pend_reg <= rd_en;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item, position, result and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg         <= opcode_t'(opcode);
            item_reg.key   <= key;
            item_reg.pay_a <= payload_a;
            item_reg.pay_b <= payload_b;
            item_reg.pay_c <= payload_c;
        end
        if (cmd.scan && scan_done)
        begin
            pos_reg <= scan_gt ? CNT_W'(rd_addr_reg) : count_reg;
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_a_reg      <= cmd.res_payload ? rd_data_reg.pay_a : '0;
            res_b_reg      <= cmd.res_payload ? rd_data_reg.pay_b : '0;
            res_c_reg      <= cmd.res_payload ? rd_data_reg.pay_c : '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_a_reg      <= res_a_reg;
            out_b_reg      <= res_b_reg;
            out_c_reg      <= res_c_reg;
        end
    end

    // status to controller
    assign stat.is_lookup  = (op_reg == OP_LOOKUP);
    assign stat.full       = is_full;
    assign stat.scan_hit   = scan_hit;
    assign stat.scan_stop  = scan_gt || scan_end;
    assign stat.shift_done = !rd_pend_reg && !(ptr_reg > pos_reg);
    assign stat.out_busy   = out_valid_reg && !out_ready;

    // result port
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign found_a   = out_a_reg;
    assign found_b   = out_b_reg;
    assign found_c   = out_c_reg;

endmodule

// ===== hdl/sorted_key_table_insert_lookup_core.sv =====
// Sorted key table: up to TABLE_DEPTH rows kept ascending by a 64-bit key,
// each row carrying three 64-bit payload words.
// Input channel (in_valid/in_ready): opcode selects insert or lookup; the key
// and payload words come with it. Output channel (out_valid/out_ready): one
// result transaction per input transaction, status plus three found words.
// Configuration: cfg_wr_en writes capacity_limit from cfg_wr_data at once.
// One transaction is worked at a time through a row memory with one read
// port, one write port and registered read. An insert into a full table is
// answered without a scan. A lookup scans rows upward until it finds the
// key, a larger key or the end; an insert scans the same way, then shifts
// the rows at and above its place up one row and writes the new row. One row
// is read per cycle in the scan and one row moved per cycle in the shift.
// A finished result sits in the output register; the next transaction is
// accepted while it waits. If out_ready stays low, the following result is
// held and in_ready stays low until the output register frees.
// Reset empties the table and sets capacity_limit to 64.
module sorted_key_table_insert_lookup_core
    import sktab_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              opcode,
    input  logic [WORD_W-1:0] key,
    input  logic [WORD_W-1:0] payload_a,
    input  logic [WORD_W-1:0] payload_b,
    input  logic [WORD_W-1:0] payload_c,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [WORD_W-1:0] found_a,
    output logic [WORD_W-1:0] found_b,
    output logic [WORD_W-1:0] found_c,
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    sktab_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table memory, compare and result registers
    sktab_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .key         (key),
        .payload_a   (payload_a),
        .payload_b   (payload_b),
        .payload_c   (payload_c),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found_a     (found_a),
        .found_b     (found_b),
        .found_c     (found_c)
    );

endmodule

// ===== verif/sorted_key_table_checker.sv =====
module sorted_key_table_checker
    import sktab_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              opcode,
    input  logic [WORD_W-1:0] key,
    input  logic [WORD_W-1:0] payload_a,
    input  logic [WORD_W-1:0] payload_b,
    input  logic [WORD_W-1:0] payload_c,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [1:0]        status,
    input  logic [WORD_W-1:0] found_a,
    input  logic [WORD_W-1:0] found_b,
    input  logic [WORD_W-1:0] found_c,
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data,
    output int                outstanding,
    output int                errors
);

    typedef struct {
        status_t           status;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
    } reply_t;

    // shadow copy of the table and its capacity register
    entry_t           rows [TABLE_DEPTH];
    int               row_count;
    logic [CAP_W-1:0] capacity;
    reply_t           awaited_replies [$];

    // apply one insert or lookup to the shadow table, return its reply
    function automatic reply_t table_apply(opcode_t op, logic [WORD_W-1:0] k,
                                           logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                                           logic [WORD_W-1:0] c);
        reply_t r;
        int     usable;
        int     pos;
        bit     hit;
        r.status = ST_OK;
        r.a      = '0;
        r.b      = '0;
        r.c      = '0;
        // capacity above the built depth acts as the depth
        usable = (int'(capacity) > TABLE_DEPTH) ? TABLE_DEPTH : int'(capacity);

        // first row whose key is not below k
        pos = 0;
        hit = 1'b0;
        while (pos < row_count)
        begin
            if (rows[pos].key == k)
            begin
                hit = 1'b1;
                break;
            end
            if (rows[pos].key > k)
                break;
            pos++;
        end

        if (op == OP_INSERT)
        begin
            // full wins over duplicate
            if (row_count >= usable)
                r.status = ST_FULL;
            else if (hit)
                r.status = ST_DUP;
            else
            begin
                for (int i = row_count; i > pos; i--)
                    rows[i] = rows[i-1];
                rows[pos].key   = k;
                rows[pos].pay_a = a;
                rows[pos].pay_b = b;
                rows[pos].pay_c = c;
                row_count++;
            end
        end
        else if (!hit)
            r.status = ST_MISS;
        else
        begin
            r.a = rows[pos].pay_a;
            r.b = rows[pos].pay_b;
            r.c = rows[pos].pay_c;
        end
        return r;
    endfunction

    task automatic report_bad_reply(string what, reply_t want, reply_t got);
        if (errors < 10)
            $display("%0t: %s: expected status %s a %h b %h c %h, got status %s a %h b %h c %h",
                     $time, what, want.status.name(), want.a, want.b, want.c,
                     got.status.name(), got.a, got.b, got.c);
        errors++;
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        reply_t got;
        reply_t want;
        if (!rst_n)
        begin
            row_count = 0;
            capacity  = CAP_RESET;
            awaited_replies.delete();
            outstanding <= 0;
            errors = 0;
        end
        else
        begin
            // result transaction against the oldest prediction
            if (out_valid && out_ready)
            begin
                got.status = status_t'(status);
                got.a      = found_a;
                got.b      = found_b;
                got.c      = found_c;
                if (awaited_replies.size() == 0)
                begin
                    want.status = ST_OK;
                    want.a      = '0;
                    want.b      = '0;
                    want.c      = '0;
                    report_bad_reply("result with nothing pending", want, got);
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (got.status !== want.status || got.a !== want.a ||
                        got.b !== want.b || got.c !== want.c)
                        report_bad_reply("result mismatch", want, got);
                end
            end

            // input transaction updates the shadow table
            if (in_valid && in_ready)
                awaited_replies.push_back(table_apply(opcode_t'(opcode), key,
                                                      payload_a, payload_b, payload_c));

            // register write takes effect after this edge
            if (cfg_wr_en)
                capacity = cfg_wr_data;

            outstanding <= awaited_replies.size();
        end
    end

endmodule

// ===== verif/tb_sorted_key_table_insert_lookup_core.sv =====
module tb_sorted_key_table_insert_lookup_core;
    import sktab_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int PHASES       = 10;
    localparam int RUN_LIMIT    = 2000000;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic              opcode      = OP_INSERT;
    logic [WORD_W-1:0] key         = '0;
    logic [WORD_W-1:0] payload_a   = '0;
    logic [WORD_W-1:0] payload_b   = '0;
    logic [WORD_W-1:0] payload_c   = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic [1:0]        status;
    logic [WORD_W-1:0] found_a;
    logic [WORD_W-1:0] found_b;
    logic [WORD_W-1:0] found_c;
    logic              cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]  cfg_wr_data = '0;
    int                outstanding;
    int                errors;

    // sender pacing mode and keys already offered for insert
    bit                tx_calm = 1'b0;
    logic [WORD_W-1:0] sent_keys [$];

    sorted_key_table_insert_lookup_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .key        (key),
        .payload_a  (payload_a),
        .payload_b  (payload_b),
        .payload_c  (payload_c),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .found_a    (found_a),
        .found_b    (found_b),
        .found_c    (found_c),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    sorted_key_table_checker table_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .key        (key),
        .payload_a  (payload_a),
        .payload_b  (payload_b),
        .payload_c  (payload_c),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .found_a    (found_a),
        .found_b    (found_b),
        .found_c    (found_c),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .outstanding(outstanding),
        .errors     (errors)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #(RUN_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stall before each transaction, calm stretches too
    initial
    begin
        int stall;
        bit rx_calm;
        rx_calm = 1'b0;
        forever
        begin
            if ($urandom_range(0, 23) == 0)
                rx_calm = ~rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 16);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // offer one transaction after a random gap, return once accepted
    task automatic send_item(opcode_t op, logic [WORD_W-1:0] k, logic [WORD_W-1:0] a,
                             logic [WORD_W-1:0] b, logic [WORD_W-1:0] c);
        int gap;
        if ($urandom_range(0, 23) == 0)
            tx_calm = ~tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        key       <= k;
        payload_a <= a;
        payload_b <= b;
        payload_c <= c;
        if (op == OP_INSERT)
            sent_keys.push_back(k);
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    // stop offering and wait for every pending result
    task automatic wait_for_replies();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic set_capacity(int v);
        wait_for_replies();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CAP_W'(v);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // random mix, biased toward keys already offered for insert and their upper neighbors
    task automatic run_mixed(int count);
        int                sel;
        opcode_t           op;
        logic [WORD_W-1:0] k;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        for (int n = 0; n < count; n++)
        begin
            op  = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_LOOKUP;
            sel = $urandom_range(0, 99);
            if (sel < 40 && sent_keys.size() != 0)
                k = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
            else if (sel < 50 && sent_keys.size() != 0)
                k = sent_keys[$urandom_range(0, sent_keys.size() - 1)] + 1;
            else if (sel < 70)
                k = WORD_W'($urandom_range(0, 300));
            else if (sel < 76)
            begin
                case ($urandom_range(0, 3))
                    0:       k = '0;
                    1:       k = '1;
                    2:       k = {1'b1, {(WORD_W-1){1'b0}}};
                    default: k = {{(WORD_W-1){1'b1}}, 1'b0};
                endcase
            end
            else
                k = {$urandom, $urandom};
            a = ($urandom_range(0, 15) == 0) ? '1 : {$urandom, $urandom};
            b = ($urandom_range(0, 15) == 0) ? '0 : {$urandom, $urandom};
            c = ($urandom_range(0, 15) == 0) ? '1 : {$urandom, $urandom};
            send_item(op, k, a, b, c);
        end
    endtask

    // reset, directed cases, random phases, verdict
    initial
    begin
        int phase_caps [PHASES];
        phase_caps = '{2, 9, 20, 33, 127, 64, 100, 1, 0, 64};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero capacity: insert is full, lookups on the empty table miss
        set_capacity(0);
        send_item(OP_INSERT, 64'd5, '1, '1, '1);
        send_item(OP_LOOKUP, 64'd5, '1, '0, '1);
        send_item(OP_LOOKUP, '1, '0, '0, '0);

        // capacity beyond the depth; key extremes, front, middle, end, duplicates
        set_capacity(127);
        send_item(OP_INSERT, '0, '1, '1, '1);
        send_item(OP_INSERT, '1, '0, '0, '0);
        send_item(OP_INSERT, 64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA,
                  64'h5555_5555_5555_5555, 64'h0123_4567_89AB_CDEF);
        send_item(OP_INSERT, 64'h10, 64'hFEDC_BA98_7654_3210, '1, '0);
        send_item(OP_INSERT, '1, '1, '1, '1);
        send_item(OP_INSERT, '0, '0, '0, '0);
        send_item(OP_INSERT, 64'd1, 64'h5555_5555_5555_5555,
                  64'hAAAA_AAAA_AAAA_AAAA, '1);
        send_item(OP_LOOKUP, '0, '0, '0, '0);
        send_item(OP_LOOKUP, 64'd1, '1, '1, '1);
        send_item(OP_LOOKUP, 64'h10, '0, '0, '0);
        send_item(OP_LOOKUP, 64'h8000_0000_0000_0000, '0, '0, '0);
        send_item(OP_LOOKUP, '1, '0, '0, '0);
        send_item(OP_LOOKUP, 64'd2, '0, '0, '0);
        send_item(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, '0, '0, '0);

        // capacity lowered below the row count: rows stay, inserts are full
        set_capacity(3);
        send_item(OP_INSERT, 64'd7, '1, '1, '1);
        send_item(OP_INSERT, 64'h10, '1, '1, '1);
        send_item(OP_LOOKUP, 64'h8000_0000_0000_0000, '1, '1, '1);
        send_item(OP_LOOKUP, '1, '1, '1, '1);

        // random phases, each under its own capacity
        for (int p = 0; p < PHASES; p++)
        begin
            set_capacity(phase_caps[p]);
            run_mixed(RANDOM_ITEMS / PHASES);
        end

        wait_for_replies();
        repeat (80) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
